// ===== hw/rtl/usct_pkg.sv =====
// ----------------------------------------------------------------------------
// usct_pkg
// Shared constants and types of the SOF clock trim loop.
// ----------------------------------------------------------------------------
`default_nettype none

package usct_pkg;

    localparam int TIMER_BITS_DEF  = 16;
    localparam int COARSE_BITS_DEF = 5;
    localparam int FINE_BITS_DEF   = 8;

    localparam int CFG_IVAL_W   = 16;
    localparam int CFG_HOLD_W   = 10;
    localparam int CFG_COARSE_W = 5;
    localparam int CFG_FINE_W   = 8;
    localparam int MEAS_W       = 16;
    localparam int CNT_W        = 11;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam logic [CFG_IVAL_W-1:0]   NOMINAL_RST  = CFG_IVAL_W'(6000);
    localparam logic [CFG_IVAL_W-1:0]   LOW_LIM_RST  = CFG_IVAL_W'(5000);
    localparam logic [CFG_IVAL_W-1:0]   HIGH_LIM_RST = CFG_IVAL_W'(7000);
    localparam logic [CFG_HOLD_W-1:0]   HOLD_RST     = CFG_HOLD_W'(1000);
    localparam logic [CFG_COARSE_W-1:0] COARSE_RST   = CFG_COARSE_W'(15);
    localparam logic [CFG_FINE_W-1:0]   FINE_RST     = CFG_FINE_W'(127);

    localparam int FINE_JUMP_BASE = 90;

    localparam logic [CNT_W-1:0] CNT_ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_SUSPEND = CNT_W'(2);

    typedef enum logic [2:0] {
        REG_NOMINAL  = 3'd0,
        REG_LOW_LIM  = 3'd1,
        REG_HIGH_LIM = 3'd2,
        REG_HOLD     = 3'd3,
        REG_START_C  = 3'd4,
        REG_START_F  = 3'd5
    } usct_reg_t;

    typedef enum logic {
        EV_SOF     = 1'b0,
        EV_SUSPEND = 1'b1
    } usct_event_t;

    typedef struct packed {
        logic [CFG_IVAL_W-1:0]   nominal;
        logic [CFG_IVAL_W-1:0]   low_lim;
        logic [CFG_IVAL_W-1:0]   high_lim;
        logic [CFG_HOLD_W-1:0]   hold;
        logic [CFG_COARSE_W-1:0] start_coarse;
        logic [CFG_FINE_W-1:0]   start_fine;
    } usct_cfg_t;

    typedef struct packed {
        logic tune_write;
        logic locked;
        logic open_loop_switch;
        logic interval_rejected;
    } usct_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/usct_step.sv =====
// ----------------------------------------------------------------------------
// usct_step
// Single-pass update of the trim loop state for one event word.
// ----------------------------------------------------------------------------
`default_nettype none

module usct_step import usct_pkg::*; #(
    parameter int TIMER_BITS  = TIMER_BITS_DEF,
    parameter int COARSE_BITS = COARSE_BITS_DEF,
    parameter int FINE_BITS   = FINE_BITS_DEF
) (
    input  wire usct_cfg_t              cfg,
    input  wire                         mode,
    input  wire [TIMER_BITS-1:0]        stamp,
    input  wire [CNT_W-1:0]             cnt,
    input  wire                         phase,
    input  wire [TIMER_BITS-1:0]        prev,
    input  wire [COARSE_BITS-1:0]       coarse,
    input  wire [FINE_BITS-1:0]         fine,
    input  wire                         sync,
    input  wire                         ol_active,
    output logic [CNT_W-1:0]            cnt_next,
    output logic                        phase_next,
    output logic [TIMER_BITS-1:0]       prev_next,
    output logic [COARSE_BITS-1:0]      coarse_next,
    output logic [FINE_BITS-1:0]        fine_next,
    output logic                        sync_next,
    output logic                        ol_active_next,
    output usct_flags_t                 flags,
    output logic [MEAS_W-1:0]           meas
);

    localparam int IW    = (TIMER_BITS > MEAS_W) ? TIMER_BITS : MEAS_W;
    localparam int XW    = MEAS_W + 1;
    localparam int NW    = ((FINE_BITS + 1 > XW) ? FINE_BITS + 1 : XW) + 1;
    localparam int FMAX  = (1 << FINE_BITS) - 1;
    localparam int FMID  = FMAX >> 1;
    localparam int FJUMP = (FINE_JUMP_BASE << FINE_BITS) >> 8;
    localparam logic [FINE_BITS-1:0]   FINE_LOW  = FINE_BITS'(FMID - FJUMP);
    localparam logic [FINE_BITS-1:0]   FINE_HIGH = FINE_BITS'(FMID + FJUMP);
    localparam logic [COARSE_BITS-1:0] COARSE_MAX = '1;

    logic [TIMER_BITS-1:0] diff;
    logic [IW-1:0]         iv;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  dev;
    logic signed [XW-1:0]  step;
    logic signed [NW-1:0]  nf;
    logic                  in_range;

    always_comb begin
        diff     = stamp - prev;
        iv       = IW'(diff);
        in_range = (iv <= IW'(cfg.high_lim)) && (iv >= IW'(cfg.low_lim));
        x        = $signed({1'b0, iv[MEAS_W-1:0]}) - $signed({1'b0, cfg.nominal});
        dev      = x[XW-1] ? (x >>> 3) + XW'(1) : (x >>> 3);
        if (sync) begin
            step = dev[XW-1] ? -XW'(1) : XW'(1);
        end else begin
            step = dev;
        end
        nf = $signed({{(NW-FINE_BITS){1'b0}}, fine}) - NW'(step);
    end

    always_comb begin
        cnt_next       = cnt;
        phase_next     = phase;
        prev_next      = prev;
        coarse_next    = coarse;
        fine_next      = fine;
        sync_next      = sync;
        ol_active_next = ol_active;
        flags          = '0;
        meas           = '0;
        if (mode == EV_SUSPEND) begin
            cnt_next   = CNT_SUSPEND;
            phase_next = 1'b0;
            sync_next  = 1'b0;
        end else if (!phase && cnt > CNT_ONE) begin
            cnt_next = cnt - CNT_ONE;
        end else if (!phase) begin
            if (!ol_active) begin
                coarse_next            = COARSE_BITS'(cfg.start_coarse);
                fine_next              = FINE_BITS'(cfg.start_fine);
                ol_active_next         = 1'b1;
                flags.open_loop_switch = 1'b1;
            end
            prev_next  = stamp;
            phase_next = 1'b1;
            cnt_next   = '0;
        end else begin
            phase_next = 1'b0;
            cnt_next   = CNT_ONE;
            meas       = iv[MEAS_W-1:0];
            if (!in_range) begin
                flags.interval_rejected = 1'b1;
            end else if (dev == '0) begin
                sync_next = 1'b1;
                cnt_next  = CNT_W'(cfg.hold);
            end else begin
                flags.tune_write = 1'b1;
                if (nf < 0 || nf > NW'(FMAX)) begin
                    sync_next = 1'b0;
                    if (!dev[XW-1]) begin
                        if (coarse != '0) begin
                            coarse_next = coarse - COARSE_BITS'(1);
                        end
                        fine_next = FINE_LOW;
                    end else begin
                        if (coarse != COARSE_MAX) begin
                            coarse_next = coarse + COARSE_BITS'(1);
                        end
                        fine_next = FINE_HIGH;
                    end
                end else begin
                    fine_next = nf[FINE_BITS-1:0];
                end
            end
        end
        flags.locked = sync_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/usb_sof_clock_trim_loop.sv =====
// The result word is registered from the event word as that word is taken.
// Throughput: one event word per cycle while the output is not stalled;
// the whole update is a single pass between the state and output registers.
// s_tready stays high while the output register is empty or being drained.
// Reset (aresetn low, synchronous): loop state and registers return to their
// defaults, output register empties.
// ----------------------------------------------------------------------------
// usb_sof_clock_trim_loop
// Oscillator coarse/fine trim from USB start-of-frame timestamps.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_sof_clock_trim_loop import usct_pkg::*; #(
    parameter int TIMER_BITS  = TIMER_BITS_DEF,
    parameter int COARSE_BITS = COARSE_BITS_DEF,
    parameter int FINE_BITS   = FINE_BITS_DEF,
    parameter int IN_TW  = ((TIMER_BITS + 7) / 8) * 8,
    parameter int OUT_TW = ((COARSE_BITS + FINE_BITS + 4 + MEAS_W + 7) / 8) * 8
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire [IN_TW-1:0]        s_tdata,   // timer_value
    input  wire                    s_tuser,   // mode
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // tune_write, coarse_tune, fine_tune, locked, open_loop_switch,
    // interval_rejected, measured_interval
    output logic [OUT_TW-1:0]      m_tdata,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [APB_ADDR_W-1:0]   paddr,
    input  wire [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    usct_cfg_t              cfg_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   phase_reg, phase_next;
    logic [TIMER_BITS-1:0]  prev_reg, prev_next;
    logic [COARSE_BITS-1:0] coarse_reg, coarse_next;
    logic [FINE_BITS-1:0]   fine_reg, fine_next;
    logic                   sync_reg, sync_next;
    logic                   ol_reg, ol_next;
    logic                   m_tvalid_reg;
    logic [OUT_TW-1:0]      m_tdata_reg, m_tdata_next;
    usct_flags_t            flags;
    logic [MEAS_W-1:0]      meas;
    logic                   s_acc;
    logic                   cfg_wr;
    usct_reg_t              reg_idx;

    assign pready   = 1'b1;
    assign reg_idx  = usct_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        case (reg_idx)
            REG_NOMINAL:  prdata = APB_DATA_W'(cfg_reg.nominal);
            REG_LOW_LIM:  prdata = APB_DATA_W'(cfg_reg.low_lim);
            REG_HIGH_LIM: prdata = APB_DATA_W'(cfg_reg.high_lim);
            REG_HOLD:     prdata = APB_DATA_W'(cfg_reg.hold);
            REG_START_C:  prdata = APB_DATA_W'(cfg_reg.start_coarse);
            REG_START_F:  prdata = APB_DATA_W'(cfg_reg.start_fine);
            default:      prdata = '0;
        endcase
    end

    usct_step #(
        .TIMER_BITS  (TIMER_BITS),
        .COARSE_BITS (COARSE_BITS),
        .FINE_BITS   (FINE_BITS)
    ) u_step (
        .cfg            (cfg_reg),
        .mode           (s_tuser),
        .stamp          (s_tdata[TIMER_BITS-1:0]),
        .cnt            (cnt_reg),
        .phase          (phase_reg),
        .prev           (prev_reg),
        .coarse         (coarse_reg),
        .fine           (fine_reg),
        .sync           (sync_reg),
        .ol_active      (ol_reg),
        .cnt_next       (cnt_next),
        .phase_next     (phase_next),
        .prev_next      (prev_next),
        .coarse_next    (coarse_next),
        .fine_next      (fine_next),
        .sync_next      (sync_next),
        .ol_active_next (ol_next),
        .flags          (flags),
        .meas           (meas)
    );

    assign m_tdata_next = OUT_TW'({meas, flags.interval_rejected, flags.open_loop_switch,
                                   flags.locked, fine_next, coarse_next, flags.tune_write});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nominal      <= NOMINAL_RST;
            cfg_reg.low_lim      <= LOW_LIM_RST;
            cfg_reg.high_lim     <= HIGH_LIM_RST;
            cfg_reg.hold         <= HOLD_RST;
            cfg_reg.start_coarse <= COARSE_RST;
            cfg_reg.start_fine   <= FINE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_NOMINAL:  cfg_reg.nominal      <= pwdata[CFG_IVAL_W-1:0];
                REG_LOW_LIM:  cfg_reg.low_lim      <= pwdata[CFG_IVAL_W-1:0];
                REG_HIGH_LIM: cfg_reg.high_lim     <= pwdata[CFG_IVAL_W-1:0];
                REG_HOLD:     cfg_reg.hold         <= pwdata[CFG_HOLD_W-1:0];
                REG_START_C:  cfg_reg.start_coarse <= pwdata[CFG_COARSE_W-1:0];
                REG_START_F:  cfg_reg.start_fine   <= pwdata[CFG_FINE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= CNT_ONE;
            phase_reg    <= 1'b0;
            prev_reg     <= '0;
            coarse_reg   <= '0;
            fine_reg     <= '0;
            sync_reg     <= 1'b0;
            ol_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                cnt_reg    <= cnt_next;
                phase_reg  <= phase_next;
                prev_reg   <= prev_next;
                coarse_reg <= coarse_next;
                fine_reg   <= fine_next;
                sync_reg   <= sync_next;
                ol_reg     <= ol_next;
            end
            if (s_acc) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/usct_checker.sv =====
// ----------------------------------------------------------------------------
// usct_checker
// Port-level checks of the SOF clock trim loop, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module usct_checker import usct_pkg::*; #(
    parameter int COARSE_BITS = COARSE_BITS_DEF,
    parameter int FINE_BITS   = FINE_BITS_DEF,
    parameter int OUT_TW = ((COARSE_BITS + FINE_BITS + 4 + MEAS_W + 7) / 8) * 8
) (
    input wire                    aclk,
    input wire                    aresetn,
    input wire                    s_tready,
    input wire                    m_tvalid,
    input wire                    m_tready,
    input wire [OUT_TW-1:0]       m_tdata
);

    localparam int LOCK_B = COARSE_BITS + FINE_BITS + 1;
    localparam int OLS_B  = LOCK_B + 1;
    localparam int REJ_B  = LOCK_B + 2;
    localparam int MEAS_L = LOCK_B + 3;

    logic wr_bit, ols_bit, rej_bit;
    logic [MEAS_W-1:0] meas;

    assign wr_bit  = m_tdata[0];
    assign ols_bit = m_tdata[OLS_B];
    assign rej_bit = m_tdata[REJ_B];
    assign meas    = m_tdata[MEAS_L + MEAS_W - 1:MEAS_L];

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under backpressure");

    // input side open whenever output register can take a word
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output register");

    // open-loop switch frame only stores a stamp
    a_ols: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ols_bit |-> !wr_bit && !rej_bit && meas == '0)
        else $error("open-loop switch word carries a measurement");

    // rejected interval never retunes
    a_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && rej_bit |-> !wr_bit)
        else $error("tuning written on rejected interval");

    // output register empty after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

endmodule

bind usb_sof_clock_trim_loop usct_checker #(
    .COARSE_BITS (COARSE_BITS),
    .FINE_BITS   (FINE_BITS),
    .OUT_TW      (OUT_TW)
) u_usct_checker (.*);

`default_nettype wire
